// ===== sv/ps2_set1_scancode_decoder_unit_assert.svh =====
// Assertion macros for the scan code decoder.
// Each macro checks on rising clk_i and is disabled while rst_ni is low.
`ifndef PS2_SET1_SCANCODE_DECODER_UNIT_ASSERT_SVH
`define PS2_SET1_SCANCODE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PS2_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ps2 decoder check failed");

// Next-cycle implication.
`define PS2_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2 decoder check failed");

`endif

// ===== sv/ps2s1_pkg.sv =====
`timescale 1ns / 1ps

package ps2s1_pkg;

  localparam logic [7:0] CodePrefix  = 8'hE0;
  localparam logic [7:0] CodeCtrlMk  = 8'h1D;
  localparam logic [7:0] CodeCtrlBrk = 8'h9D;
  localparam logic [7:0] CodeAltMk   = 8'h38;
  localparam logic [7:0] CodeAltBrk  = 8'hB8;

  localparam logic [6:0] ScUp    = 7'h48;
  localparam logic [6:0] ScDown  = 7'h50;
  localparam logic [6:0] ScLeft  = 7'h4B;
  localparam logic [6:0] ScRight = 7'h4D;
  localparam logic [6:0] ScHome  = 7'h47;
  localparam logic [6:0] ScEnd   = 7'h4F;
  localparam logic [6:0] ScPgUp  = 7'h49;
  localparam logic [6:0] ScPgDn  = 7'h51;

  localparam logic [6:0] KeyNone  = 7'd0;
  localparam logic [6:0] KeyUp    = 7'd1;
  localparam logic [6:0] KeyDown  = 7'd2;
  localparam logic [6:0] KeyLeft  = 7'd3;
  localparam logic [6:0] KeyRight = 7'd4;
  localparam logic [6:0] KeyHome  = 7'd5;
  localparam logic [6:0] KeyEnd   = 7'd6;
  localparam logic [6:0] KeyPgUp  = 7'd7;
  localparam logic [6:0] KeyPgDn  = 7'd8;

  typedef struct packed {
    logic [6:0] key_code;
    logic       key_valid;
    logic       key_with_ctrl;
    logic       ctrl_held;
    logic       alt_held;
  } res_t;

  function automatic logic [6:0] nav_code(input logic [6:0] sc);
    logic [6:0] k;
    case (sc)
      ScUp:    k = KeyUp;
      ScDown:  k = KeyDown;
      ScLeft:  k = KeyLeft;
      ScRight: k = KeyRight;
      ScHome:  k = KeyHome;
      ScEnd:   k = KeyEnd;
      ScPgUp:  k = KeyPgUp;
      ScPgDn:  k = KeyPgDn;
      default: k = KeyNone;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] ascii_code(input logic [6:0] sc);
    logic [6:0] a;
    case (sc)
      7'h01: a = 7'h1B;
      7'h02: a = 7'h31;
      7'h03: a = 7'h32;
      7'h04: a = 7'h33;
      7'h05: a = 7'h34;
      7'h06: a = 7'h35;
      7'h07: a = 7'h36;
      7'h08: a = 7'h37;
      7'h09: a = 7'h38;
      7'h0A: a = 7'h39;
      7'h0B: a = 7'h30;
      7'h0C: a = 7'h2D;
      7'h0D: a = 7'h3D;
      7'h0E: a = 7'h08;
      7'h0F: a = 7'h09;
      7'h10: a = 7'h71;
      7'h11: a = 7'h77;
      7'h12: a = 7'h65;
      7'h13: a = 7'h72;
      7'h14: a = 7'h74;
      7'h15: a = 7'h79;
      7'h16: a = 7'h75;
      7'h17: a = 7'h69;
      7'h18: a = 7'h6F;
      7'h19: a = 7'h70;
      7'h1A: a = 7'h5B;
      7'h1B: a = 7'h5D;
      7'h1C: a = 7'h0A;
      7'h1E: a = 7'h61;
      7'h1F: a = 7'h73;
      7'h20: a = 7'h64;
      7'h21: a = 7'h66;
      7'h22: a = 7'h67;
      7'h23: a = 7'h68;
      7'h24: a = 7'h6A;
      7'h25: a = 7'h6B;
      7'h26: a = 7'h6C;
      7'h27: a = 7'h3B;
      7'h28: a = 7'h27;
      7'h29: a = 7'h60;
      7'h2B: a = 7'h5C;
      7'h2C: a = 7'h7A;
      7'h2D: a = 7'h78;
      7'h2E: a = 7'h63;
      7'h2F: a = 7'h76;
      7'h30: a = 7'h62;
      7'h31: a = 7'h6E;
      7'h32: a = 7'h6D;
      7'h33: a = 7'h2C;
      7'h34: a = 7'h2E;
      7'h35: a = 7'h2F;
      7'h37: a = 7'h2A;
      7'h39: a = 7'h20;
      default: a = KeyNone;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/ps2_set1_scancode_decoder_unit.sv =====
`timescale 1ns / 1ps
// PS/2 scan code set 1 decoder.
// Input channel: one keyboard byte per beat on scancode_i, qualified by
// in_valid_i and held off by in_stall_o.
// Output channel: one result beat per input byte (key_code_o, key_valid_o,
// key_with_ctrl_o, ctrl_held_o, alt_held_o), qualified by out_valid_o and
// held off by out_stall_i.
// The byte is decoded in the cycle it is accepted against the prefix, ctrl
// and alt flags; its result is registered in the output or skid register.
// Throughput is one byte per cycle while in_stall_o is low.
// A skid register behind the output register takes one more result while
// the receiver stalls; in_stall_o rises only once the skid register holds
// a beat, so input stall is registered and never follows out_stall_i
// combinationally. Stalled results stay unchanged until taken.
// Reset clears the E0 prefix flag, the ctrl and alt flags and both valid
// flags; no result is pending after reset.
module ps2_set1_scancode_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scancode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] key_code_o,
  output logic       key_valid_o,
  output logic       key_with_ctrl_o,
  output logic       ctrl_held_o,
  output logic       alt_held_o
);

  logic prefix_q, prefix_d;
  logic ctrl_q, ctrl_d;
  logic alt_q, alt_d;
  logic out_vld_q, out_vld_d;
  logic skid_vld_q, skid_vld_d;
  ps2s1_pkg::res_t out_q, out_d;
  ps2s1_pkg::res_t skid_q, skid_d;
  ps2s1_pkg::res_t res;
  logic [6:0] code;
  logic in_acc;
  logic out_take;

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;
  assign out_take   = out_vld_q && !out_stall_i;

  always_comb begin
    prefix_d = prefix_q;
    ctrl_d   = ctrl_q;
    alt_d    = alt_q;
    code     = ps2s1_pkg::KeyNone;
    if (scancode_i == ps2s1_pkg::CodePrefix) begin
      prefix_d = 1'b1;
    end else begin
      prefix_d = 1'b0;
      if (scancode_i == ps2s1_pkg::CodeCtrlMk) begin
        ctrl_d = 1'b1;
      end else if (scancode_i == ps2s1_pkg::CodeCtrlBrk) begin
        ctrl_d = 1'b0;
      end else if (scancode_i == ps2s1_pkg::CodeAltMk) begin
        alt_d = 1'b1;
      end else if (scancode_i == ps2s1_pkg::CodeAltBrk) begin
        alt_d = 1'b0;
      end else if (!scancode_i[7]) begin
        code = prefix_q ? ps2s1_pkg::nav_code(scancode_i[6:0])
                        : ps2s1_pkg::ascii_code(scancode_i[6:0]);
      end
    end
    res.key_code      = code;
    res.key_valid     = (code != ps2s1_pkg::KeyNone);
    res.key_with_ctrl = (code != ps2s1_pkg::KeyNone) && ctrl_d;
    res.ctrl_held     = ctrl_d;
    res.alt_held      = alt_d;
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (out_take) begin
      out_vld_d = 1'b0;
    end
    if (skid_vld_q && out_take) begin
      out_d      = skid_q;
      out_vld_d  = 1'b1;
      skid_vld_d = 1'b0;
    end
    if (in_acc) begin
      if (!out_vld_q || out_take) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q   <= 1'b0;
      ctrl_q     <= 1'b0;
      alt_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        prefix_q <= prefix_d;
        ctrl_q   <= ctrl_d;
        alt_q    <= alt_d;
      end
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_vld_q;
  assign key_code_o      = out_q.key_code;
  assign key_valid_o     = out_q.key_valid;
  assign key_with_ctrl_o = out_q.key_with_ctrl;
  assign ctrl_held_o     = out_q.ctrl_held;
  assign alt_held_o      = out_q.alt_held;

  `include "ps2_set1_scancode_decoder_unit_assert.svh"

  `PS2_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q)
  `PS2_ASSERT_NXT(a_stalled_beat_kept, out_vld_q && out_stall_i, out_vld_q)
  `PS2_ASSERT_IMP(a_valid_matches_code, out_vld_q,
                  key_valid_o == (key_code_o != ps2s1_pkg::KeyNone))
  `PS2_ASSERT_IMP(a_ctrl_tag_consistent, out_vld_q && key_with_ctrl_o,
                  key_valid_o && ctrl_held_o)

endmodule

// ===== bench/tb_ps2_set1_scancode_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_ps2_set1_scancode_decoder_unit;
  import ps2s1_pkg::*;

  typedef struct {
    logic [7:0] sc;
    logic       typed;
    logic [6:0] code;
    logic       kv;
    logic       kc;
    logic       ch;
    logic       ah;
  } dir_row_t;

  localparam logic [6:0] KEY_LUT [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b1;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] scancode_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] key_code_o;
  logic       key_valid_o;
  logic       key_with_ctrl_o;
  logic       ctrl_held_o;
  logic       alt_held_o;

  logic       e0_seen = 1'b0;
  logic       ctrl_dn = 1'b0;
  logic       alt_dn = 1'b0;
  res_t       pending_keys [$];
  dir_row_t   dir_steps [25];
  logic [6:0] nav_sc [8];

  int errors = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  ps2_set1_scancode_decoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .scancode_i      (scancode_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .key_code_o      (key_code_o),
    .key_valid_o     (key_valid_o),
    .key_with_ctrl_o (key_with_ctrl_o),
    .ctrl_held_o     (ctrl_held_o),
    .alt_held_o      (alt_held_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic res_t decode_byte(input logic [7:0] b);
    res_t       r;
    logic       ext;
    logic [6:0] k;
    k = KeyNone;
    if (b == CodePrefix) begin
      e0_seen = 1'b1;
    end else begin
      ext = e0_seen;
      e0_seen = 1'b0;
      if (b == CodeCtrlMk) begin
        ctrl_dn = 1'b1;
      end else if (b == CodeCtrlBrk) begin
        ctrl_dn = 1'b0;
      end else if (b == CodeAltMk) begin
        alt_dn = 1'b1;
      end else if (b == CodeAltBrk) begin
        alt_dn = 1'b0;
      end else if (!b[7]) begin
        if (ext) begin
          case (b[6:0])
            ScUp:    k = KeyUp;
            ScDown:  k = KeyDown;
            ScLeft:  k = KeyLeft;
            ScRight: k = KeyRight;
            ScHome:  k = KeyHome;
            ScEnd:   k = KeyEnd;
            ScPgUp:  k = KeyPgUp;
            ScPgDn:  k = KeyPgDn;
            default: k = KeyNone;
          endcase
        end else if (!b[6]) begin
          k = KEY_LUT[b[5:0]];
        end
      end
    end
    r.key_code      = k;
    r.key_valid     = (k != KeyNone);
    r.key_with_ctrl = (k != KeyNone) && ctrl_dn;
    r.ctrl_held     = ctrl_dn;
    r.alt_held      = alt_dn;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic use_typed, input res_t typed_res);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    scancode_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    r = decode_byte(b);
    pending_keys.push_back(use_typed ? typed_res : r);
    bytes_sent++;
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_token != hold_seen) begin
      hold_seen   <= hold_token;
      hold_left   <= 80;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected beat exp none got key_code=%h", $time, key_code_o);
        errors++;
      end else begin
        e = pending_keys.pop_front();
        if (key_code_o !== e.key_code) begin
          $display("%0t: key_code exp %h got %h", $time, e.key_code, key_code_o);
          errors++;
        end
        if (key_valid_o !== e.key_valid) begin
          $display("%0t: key_valid exp %b got %b", $time, e.key_valid, key_valid_o);
          errors++;
        end
        if (key_with_ctrl_o !== e.key_with_ctrl) begin
          $display("%0t: key_with_ctrl exp %b got %b", $time, e.key_with_ctrl,
                   key_with_ctrl_o);
          errors++;
        end
        if (ctrl_held_o !== e.ctrl_held) begin
          $display("%0t: ctrl_held exp %b got %b", $time, e.ctrl_held, ctrl_held_o);
          errors++;
        end
        if (alt_held_o !== e.alt_held) begin
          $display("%0t: alt_held exp %b got %b", $time, e.alt_held, alt_held_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int         kind;
    int         idx;
    int         target;
    logic [7:0] mk;
    res_t       t;
    rst_ni <= 1'b0;
    nav_sc = '{ScUp, ScDown, ScLeft, ScRight, ScHome, ScEnd, ScPgUp, ScPgDn};
    dir_steps = '{
      '{8'h00, 1'b1, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h01, 1'b1, 7'h1B, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h7F, 1'b1, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h1D, 1'b1, 7'h00, 1'b0, 1'b0, 1'b1, 1'b0},
      '{8'h1E, 1'b1, 7'h61, 1'b1, 1'b1, 1'b1, 1'b0},
      '{8'h38, 1'b1, 7'h00, 1'b0, 1'b0, 1'b1, 1'b1},
      '{8'hE0, 1'b1, 7'h00, 1'b0, 1'b0, 1'b1, 1'b1},
      '{8'hE0, 1'b1, 7'h00, 1'b0, 1'b0, 1'b1, 1'b1},
      '{8'h48, 1'b1, KeyUp, 1'b1, 1'b1, 1'b1, 1'b1},
      '{8'hE0, 1'b1, 7'h00, 1'b0, 1'b0, 1'b1, 1'b1},
      '{8'h9D, 1'b1, 7'h00, 1'b0, 1'b0, 1'b0, 1'b1},
      '{8'hE0, 1'b1, 7'h00, 1'b0, 1'b0, 1'b0, 1'b1},
      '{8'h51, 1'b1, KeyPgDn, 1'b1, 1'b0, 1'b0, 1'b1},
      '{8'hE0, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h1C, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hE0, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hC8, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h48, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hE0, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hB8, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h0E, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hE0, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h47, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h39, 1'b0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 20;
    recv_stall_pct = 62;
    foreach (dir_steps[i]) begin
      t = {dir_steps[i].code, dir_steps[i].kv, dir_steps[i].kc, dir_steps[i].ch,
           dir_steps[i].ah};
      send_byte(dir_steps[i].sc, dir_steps[i].typed, t);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 20; recv_stall_pct = 62; end
        1: begin send_idle_pct = 62; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase != 1) hold_token <= hold_token + 1;
      target = bytes_sent + 142;
      while (bytes_sent < target) begin
        kind = $urandom_range(99);
        if (kind < 30) begin
          mk = {2'b00, 6'($urandom_range(0, 63))};
          send_byte(mk, 1'b0, '0);
          if ($urandom_range(1)) send_byte(mk | 8'h80, 1'b0, '0);
        end else if (kind < 55) begin
          if ($urandom_range(1)) send_byte(CodePrefix, 1'b0, '0);
          case ($urandom_range(3))
            0: send_byte(CodeCtrlMk, 1'b0, '0);
            1: send_byte(CodeCtrlBrk, 1'b0, '0);
            2: send_byte(CodeAltMk, 1'b0, '0);
            default: send_byte(CodeAltBrk, 1'b0, '0);
          endcase
        end else if (kind < 75) begin
          idx = $urandom_range(7);
          send_byte(CodePrefix, 1'b0, '0);
          send_byte({1'b0, nav_sc[idx]}, 1'b0, '0);
          if ($urandom_range(1)) begin
            send_byte(CodePrefix, 1'b0, '0);
            send_byte({1'b1, nav_sc[idx]}, 1'b0, '0);
          end
        end else if (kind < 83) begin
          send_byte(CodePrefix, 1'b0, '0);
          send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b0, '0);
        end else if (kind < 88) begin
          send_byte(CodePrefix, 1'b0, '0);
          send_byte(CodePrefix, 1'b0, '0);
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== ps2_set1_scancode_decoder_unit.f =====
+incdir+sv
sv/ps2s1_pkg.sv
sv/ps2_set1_scancode_decoder_unit.sv
bench/tb_ps2_set1_scancode_decoder_unit.sv
